### hdl/lcg48_pkg.sv
// shared types and constants of the 48-bit lcg random generator
package lcg48_pkg;

    localparam int SEED_W = 48;
    localparam int MUL_W  = 35;
    localparam int CHUNK_W = 16;

    localparam logic [MUL_W-1:0]  LCG_MUL   = 35'h5DEECE66D;
    localparam logic [SEED_W-1:0] LCG_MUL48 = 48'h0005DEECE66D;
    localparam logic [SEED_W-1:0] LCG_INC   = 48'h00000000000B;

    // division steps for the 31-bit remainder
    localparam int DIV_STEPS = 31;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        KIND_RESEED    = 4'd0,
        KIND_RAW       = 4'd1,
        KIND_INT32     = 4'd2,
        KIND_BOUNDED   = 4'd3,
        KIND_BOOL      = 4'd4,
        KIND_FLOAT24   = 4'd5,
        KIND_DOUBLE54  = 4'd6,
        KIND_LONG      = 4'd7,
        KIND_READ_SEED = 4'd8
    } t_kind;

    typedef enum logic [3:0] {
        RES_ZERO,
        RES_SEED,
        RES_ERR,
        RES_RAW,
        RES_INT,
        RES_BOOL,
        RES_FLOAT,
        RES_DOUBLE,
        RES_LONG,
        RES_POW2,
        RES_MOD
    } t_res_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ADV0,
        S_ADV1,
        S_ADV2,
        S_ADV3,
        S_DRAW,
        S_DIV,
        S_CHECK,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [3:0]         kind;
        logic signed [63:0] seed_value;
        logic [5:0]         bit_count;
        logic signed [31:0] upper_bound;
    } t_in_word;

    typedef struct packed {
        logic signed [63:0] value;
        logic               error;
    } t_out_word;

    // controller to datapath
    typedef struct packed {
        logic     capture;
        logic     adv_mul;
        logic [1:0] adv_step;
        logic     acc_init;
        logic     acc_add;
        logic     seed_adv;
        logic     seed_load;
        logic     res_load;
        t_res_sel res_sel;
        logic     hi_load;
        logic     div_start;
        logic     div_step;
        logic     out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [3:0] kind;
        logic       bound_bad;
        logic       bound_pow2;
        logic       div_last;
        logic       retry;
    } t_sts;

endpackage

### hdl/lcg48_random_generator_top.sv
// top level of the 48-bit lcg random generator: sequencer plus datapath
// reseed, seed read, bad bound and unused kinds go from decode straight to the result
// register; one draw runs the seed advance steps and the draw; double and long run two
// draws; bounded non power of two bounds repeat, per draw attempt, 4 seed advance
// steps, the draw, 31 remainder steps and the retry check
// one word at a time: the next word is taken the cycle after the result is registered
// synchronous active-low reset clears the seed to zero and empties the output register
module lcg48_random_generator_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  lcg48_pkg::t_in_word  i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output lcg48_pkg::t_out_word o_out_word
);
    import lcg48_pkg::*;

    // command and status between sequencer and datapath
    t_cmd cmd;
    t_sts sts;

    // sequencer: decode, seed advance steps, remainder loop, retry and output hold
    lcg48_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // datapath: 48-bit seed, 16x35 chunked multiplier, bit-serial remainder unit,
    // result mux and output word register
    lcg48_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_word  (i_in_word),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_word (o_out_word)
    );

endmodule

### hdl/lcg48_ctrl.sv
// sequencer of the 48-bit lcg random generator
module lcg48_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic          i_out_stall,
    output logic          o_out_valid,
    input  lcg48_pkg::t_sts i_sts,
    output lcg48_pkg::t_cmd o_cmd
);
    import lcg48_pkg::*;

    t_state r_state, n_state;
    logic   r_second, n_second;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_second    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_second    <= n_second;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_second = r_second;
        o_cmd    = '0;
        o_cmd.res_sel = RES_ZERO;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_second = 1'b0;
                unique case (i_sts.kind)
                    KIND_RESEED: begin
                        o_cmd.seed_load = 1'b1;
                        o_cmd.res_load  = 1'b1;
                        o_cmd.res_sel   = RES_ZERO;
                        n_state = S_FINISH;
                    end
                    KIND_READ_SEED: begin
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_sel  = RES_SEED;
                        n_state = S_FINISH;
                    end
                    KIND_BOUNDED: begin
                        if (i_sts.bound_bad) begin
                            o_cmd.res_load = 1'b1;
                            o_cmd.res_sel  = RES_ERR;
                            n_state = S_FINISH;
                        end else begin
                            n_state = S_ADV0;
                        end
                    end
                    KIND_RAW, KIND_INT32, KIND_BOOL, KIND_FLOAT24,
                    KIND_DOUBLE54, KIND_LONG: begin
                        n_state = S_ADV0;
                    end
                    default: begin
                        // unused kinds leave the seed alone
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_sel  = RES_ZERO;
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_ADV0: begin
                o_cmd.adv_mul  = 1'b1;
                o_cmd.adv_step = 2'd0;
                o_cmd.acc_init = 1'b1;
                n_state = S_ADV1;
            end
            S_ADV1: begin
                o_cmd.adv_mul  = 1'b1;
                o_cmd.adv_step = 2'd1;
                o_cmd.acc_add  = 1'b1;
                n_state = S_ADV2;
            end
            S_ADV2: begin
                o_cmd.adv_mul  = 1'b1;
                o_cmd.adv_step = 2'd2;
                o_cmd.acc_add  = 1'b1;
                n_state = S_ADV3;
            end
            S_ADV3: begin
                o_cmd.seed_adv = 1'b1;
                n_state = S_DRAW;
            end
            S_DRAW: begin
                n_state = S_FINISH;
                o_cmd.res_load = 1'b1;
                unique case (i_sts.kind)
                    KIND_RAW:     o_cmd.res_sel = RES_RAW;
                    KIND_INT32:   o_cmd.res_sel = RES_INT;
                    KIND_BOOL:    o_cmd.res_sel = RES_BOOL;
                    KIND_FLOAT24: o_cmd.res_sel = RES_FLOAT;
                    KIND_DOUBLE54, KIND_LONG: begin
                        if (!r_second) begin
                            // first half of a two-draw result
                            o_cmd.res_load = 1'b0;
                            o_cmd.hi_load  = 1'b1;
                            n_second = 1'b1;
                            n_state  = S_ADV0;
                        end else if (i_sts.kind == KIND_LONG) begin
                            o_cmd.res_sel = RES_LONG;
                        end else begin
                            o_cmd.res_sel = RES_DOUBLE;
                        end
                    end
                    KIND_BOUNDED: begin
                        if (i_sts.bound_pow2) begin
                            o_cmd.res_sel = RES_POW2;
                        end else begin
                            o_cmd.res_load  = 1'b0;
                            o_cmd.div_start = 1'b1;
                            n_state = S_DIV;
                        end
                    end
                    default: o_cmd.res_sel = RES_ZERO;
                endcase
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.retry) begin
                    n_state = S_ADV0;
                end else begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = RES_MOD;
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE) || !i_rst_n;
    assign o_out_valid = r_out_valid;

endmodule

### hdl/lcg48_dpath.sv
// seed, multiplier, divider and result registers of the lcg random generator
module lcg48_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lcg48_pkg::t_in_word  i_in_word,
    input  lcg48_pkg::t_cmd      i_cmd,
    output lcg48_pkg::t_sts      o_sts,
    output lcg48_pkg::t_out_word o_out_word
);
    import lcg48_pkg::*;

    logic [3:0]           r_kind;
    logic [SEED_W-1:0]    r_seed_in;
    logic [5:0]           r_count;
    logic [31:0]          r_bound;
    logic [SEED_W-1:0]    r_seed, r_prod, r_acc;
    logic [SEED_W-1:0]    n_prod;
    logic [31:0]          r_hi;
    logic [30:0]          r_draw, r_dvd;
    logic [31:0]          r_rem, n_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [63:0]          r_res, n_res;
    logic                 r_err;
    t_out_word            r_out;

    logic [CHUNK_W-1:0]       mul_chunk;
    logic [CHUNK_W+MUL_W-1:0] mul_full;
    logic [31:0]              draw32;
    logic [30:0]              draw31;
    logic [5:0]               raw_n, raw_shift;
    logic [31:0]              raw_bits;
    logic [62:0]              pow_prod;
    logic [31:0]              trial;
    logic [31:0]              chk;

    // seed times multiplier, one 16-bit chunk of the seed per step
    always_comb begin
        unique case (i_cmd.adv_step)
            2'd0:    mul_chunk = r_seed[15:0];
            2'd1:    mul_chunk = r_seed[31:16];
            default: mul_chunk = r_seed[47:32];
        endcase
        mul_full = (CHUNK_W+MUL_W)'(mul_chunk) * (CHUNK_W+MUL_W)'(LCG_MUL);
        unique case (i_cmd.adv_step)
            2'd0:    n_prod = mul_full[47:0];
            2'd1:    n_prod = {mul_full[31:0], 16'b0};
            default: n_prod = {mul_full[15:0], 32'b0};
        endcase
    end

    assign draw32 = r_seed[47:16];
    assign draw31 = r_seed[47:17];

    always_comb begin
        raw_n     = (r_count > 6'd32) ? 6'd32 : r_count;
        raw_shift = 6'd32 - raw_n;
        raw_bits  = draw32 >> raw_shift;
    end

    assign pow_prod = 63'(r_bound) * 63'(draw31);

    // restoring remainder step
    always_comb begin
        trial = {r_rem[30:0], r_dvd[30]};
        n_rem = (trial >= r_bound) ? (trial - r_bound) : trial;
    end

    assign chk = {1'b0, r_draw} - r_rem + r_bound - 32'd1;

    always_comb begin
        unique case (i_cmd.res_sel)
            RES_ZERO:   n_res = 64'd0;
            RES_SEED:   n_res = {16'b0, r_seed};
            RES_ERR:    n_res = 64'd0;
            RES_RAW:    n_res = (r_count == 6'd0) ? 64'd0
                                : {{32{raw_bits[31]}}, raw_bits};
            RES_INT:    n_res = {{32{draw32[31]}}, draw32};
            RES_BOOL:   n_res = {63'b0, r_seed[47]};
            RES_FLOAT:  n_res = {40'b0, r_seed[47:24]};
            RES_DOUBLE: n_res = {10'b0, r_hi[31:5], r_seed[47:21]};
            RES_LONG:   n_res = {r_hi, 32'b0} + {{32{draw32[31]}}, draw32};
            RES_POW2:   n_res = {32'b0, pow_prod[62:31]};
            RES_MOD:    n_res = {32'b0, r_rem};
            default:    n_res = 64'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (i_cmd.seed_load) begin
            r_seed <= r_seed_in ^ LCG_MUL48;
        end else if (i_cmd.seed_adv) begin
            r_seed <= r_acc + r_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind    <= i_in_word.kind;
            r_seed_in <= i_in_word.seed_value[SEED_W-1:0];
            r_count   <= i_in_word.bit_count;
            r_bound   <= i_in_word.upper_bound;
        end
        if (i_cmd.adv_mul) begin
            r_prod <= n_prod;
        end
        if (i_cmd.acc_init) begin
            r_acc <= LCG_INC;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + r_prod;
        end
        if (i_cmd.hi_load) begin
            r_hi <= draw32;
        end
        if (i_cmd.div_start) begin
            r_draw <= draw31;
            r_dvd  <= draw31;
            r_rem  <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd  <= {r_dvd[29:0], 1'b0};
            r_rem  <= n_rem;
            r_cnt  <= r_cnt + DIV_CNT_W'(1);
        end
        if (i_cmd.res_load) begin
            r_res <= n_res;
            r_err <= (i_cmd.res_sel == RES_ERR);
        end
        if (i_cmd.out_load) begin
            r_out.value <= r_res;
            r_out.error <= r_err;
        end
    end

    always_comb begin
        o_sts.kind       = r_kind;
        o_sts.bound_bad  = (r_bound == 32'd0) || r_bound[31];
        o_sts.bound_pow2 = (r_bound & (~r_bound + 32'd1)) == r_bound;
        o_sts.div_last   = (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));
        o_sts.retry      = chk[31];
    end

    assign o_out_word = r_out;

endmodule

### hdl/lcg48_checker.sv
// port-level checks of the lcg random generator and their bind
module lcg48_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input lcg48_pkg::t_in_word  i_in_word,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input lcg48_pkg::t_out_word o_out_word
);
    import lcg48_pkg::*;

    // a held result word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed while stalled");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // an error result carries a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.error |-> o_out_word.value == 64'sd0)
        else $error("error result with nonzero value");

    // the block is busy right after taking a word
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second word taken while busy");

endmodule

bind lcg48_random_generator_top lcg48_checker u_lcg48_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
